// ===== hdl/cbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and codes of the cartridge bank mapper
// Item structs, bank state, configuration set, target and mapper codes.
// ----------------------------------------------------------------------------
package cbm_pkg;

    // Configuration port
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAPPER_KIND      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BANK_COUNT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAM_BANK_COUNT   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BOOT_ROM_PRESENT = 2'd3;

    // Mapper kinds
    localparam logic [1:0] KIND_PLAIN     = 2'd0;
    localparam logic [1:0] KIND_MBC1      = 2'd1;
    localparam logic [1:0] KIND_MBC1_MODE = 2'd2;
    localparam logic [1:0] KIND_MBC3      = 2'd3;

    // Access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Access targets
    localparam logic [2:0] TGT_NONE    = 3'd0;
    localparam logic [2:0] TGT_BOOT    = 3'd1;
    localparam logic [2:0] TGT_ROM     = 3'd2;
    localparam logic [2:0] TGT_RAM     = 3'd3;
    localparam logic [2:0] TGT_RAM_OFF = 3'd4;

    // Control write regions, address bits 14:13 below 0x8000
    localparam logic [1:0] REG_RAM_ENABLE = 2'd0;
    localparam logic [1:0] REG_ROM_BANK   = 2'd1;
    localparam logic [1:0] REG_RAM_BANK   = 2'd2;
    localparam logic [1:0] REG_MODE       = 2'd3;

    // Bus constants
    localparam logic [15:0] BOOT_OFF_ADDR  = 16'hFF50;
    localparam logic [7:0]  BOOT_OFF_DATA  = 8'h01;
    localparam logic [3:0]  RAM_EN_KEY     = 4'hA;
    localparam logic [2:0]  RAM_WINDOW_TOP = 3'b101;

    typedef struct packed {
        logic        opcode;
        logic [15:0] address;
        logic [7:0]  write_data;
    } cbm_req_t;

    typedef struct packed {
        logic [2:0]  target;
        logic [21:0] physical_address;
        logic        ram_write;
        logic [7:0]  rom_bank_now;
        logic [3:0]  ram_bank_now;
        logic        ram_on;
    } cbm_rsp_t;

    typedef struct packed {
        logic [7:0] rom_bank_select;
        logic [3:0] ram_bank_select;
        logic       ram_enable_flag;
        logic       ram_mode_flag;
        logic       boot_overlay_off;
    } cbm_state_t;

    typedef struct packed {
        logic [1:0] mapper_kind;
        logic [8:0] rom_bank_count;
        logic [4:0] ram_bank_count;
        logic       boot_rom_present;
    } cbm_cfg_t;

endpackage

// ===== hdl/cbm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_core: bank register update and address mapping
// Takes one bus access and the current bank state, gives the next state
// and the result item. Pure combinational logic.
// ----------------------------------------------------------------------------
module cbm_core (
    input  cbm_pkg::cbm_cfg_t   cfg,
    input  cbm_pkg::cbm_state_t state,
    input  cbm_pkg::cbm_req_t   req,
    output cbm_pkg::cbm_state_t state_next,
    output cbm_pkg::cbm_rsp_t   rsp
);

    logic [7:0] rom_mask;
    logic [3:0] ram_mask;
    logic       is_mbc1;
    logic [7:0] eff_bank;
    logic [3:0] ram_bank;
    logic       in_ram_window;

    // Bank masks from the bank counts
    always_comb
    begin
        rom_mask = 8'(cfg.rom_bank_count - 9'd1);
        ram_mask = (cfg.ram_bank_count == 5'd0) ? 4'd0 : 4'(cfg.ram_bank_count - 5'd1);
        is_mbc1  = cfg.mapper_kind inside {cbm_pkg::KIND_MBC1, cbm_pkg::KIND_MBC1_MODE};
    end

    // Control writes
    always_comb
    begin
        state_next = state;
        if (req.opcode == cbm_pkg::OP_WRITE)
        begin
            if (req.address == cbm_pkg::BOOT_OFF_ADDR && req.write_data == cbm_pkg::BOOT_OFF_DATA)
            begin
                state_next.boot_overlay_off = 1'b1;
            end
            if (!req.address[15])
            begin
                case (req.address[14:13])
                    cbm_pkg::REG_RAM_ENABLE:
                    begin
                        state_next.ram_enable_flag = (req.write_data[3:0] == cbm_pkg::RAM_EN_KEY);
                    end
                    cbm_pkg::REG_ROM_BANK:
                    begin
                        if (cfg.rom_bank_count > 9'd2)
                        begin
                            if (is_mbc1)
                            begin
                                state_next.rom_bank_select =
                                    {state.rom_bank_select[7:5], req.write_data[4:0]};
                            end
                            else if (cfg.mapper_kind == cbm_pkg::KIND_MBC3)
                            begin
                                state_next.rom_bank_select =
                                    {state.rom_bank_select[7], req.write_data[6:0]};
                            end
                        end
                    end
                    cbm_pkg::REG_RAM_BANK:
                    begin
                        if (is_mbc1)
                        begin
                            if (state.ram_mode_flag)
                            begin
                                state_next.ram_bank_select =
                                    {2'b00, req.write_data[1:0]} & ram_mask;
                            end
                            else
                            begin
                                state_next.rom_bank_select = {state.rom_bank_select[7],
                                    req.write_data[1:0], state.rom_bank_select[4:0]};
                                state_next.ram_bank_select = 4'd0;
                            end
                        end
                        else if (cfg.mapper_kind == cbm_pkg::KIND_MBC3)
                        begin
                            // only RAM bank numbers 0..7; RTC selects are ignored
                            if (req.write_data[7:3] == 5'd0)
                            begin
                                state_next.ram_bank_select = req.write_data[3:0] & ram_mask;
                            end
                        end
                    end
                    cbm_pkg::REG_MODE:
                    begin
                        if (cfg.mapper_kind == cbm_pkg::KIND_MBC1_MODE)
                        begin
                            state_next.ram_mode_flag = req.write_data[0];
                            if (req.write_data[0])
                            begin
                                state_next.rom_bank_select[6:5] = 2'b00;
                            end
                            else
                            begin
                                state_next.ram_bank_select = 4'd0;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = state;
                    end
                endcase
            end
        end
    end

    // Effective banks after the access (reads and RAM writes leave them alone)
    always_comb
    begin
        eff_bank = state_next.rom_bank_select;
        if (cfg.mapper_kind == cbm_pkg::KIND_PLAIN)
        begin
            eff_bank = 8'd1;
        end
        else if (is_mbc1)
        begin
            // 0x00, 0x20, 0x40, 0x60 step to the next bank
            if (!eff_bank[7] && eff_bank[4:0] == 5'd0)
            begin
                eff_bank = eff_bank | 8'd1;
            end
        end
        else if (eff_bank == 8'd0)
        begin
            eff_bank = 8'd1;
        end
        eff_bank = eff_bank & rom_mask;
        ram_bank = state_next.ram_bank_select & ram_mask;
    end

    // Target and physical address
    always_comb
    begin
        in_ram_window        = (req.address[15:13] == cbm_pkg::RAM_WINDOW_TOP);
        rsp.target           = cbm_pkg::TGT_NONE;
        rsp.physical_address = 22'd0;
        rsp.ram_write        = 1'b0;
        rsp.rom_bank_now     = eff_bank;
        rsp.ram_bank_now     = ram_bank;
        rsp.ram_on           = state_next.ram_enable_flag;
        if (req.opcode == cbm_pkg::OP_WRITE)
        begin
            if (in_ram_window)
            begin
                if (state_next.ram_enable_flag)
                begin
                    rsp.target           = cbm_pkg::TGT_RAM;
                    rsp.physical_address = {5'd0, ram_bank, req.address[12:0]};
                    rsp.ram_write        = 1'b1;
                end
                else
                begin
                    rsp.target = cbm_pkg::TGT_RAM_OFF;
                end
            end
        end
        else if (cfg.boot_rom_present && !state_next.boot_overlay_off
                 && req.address[15:8] == 8'd0)
        begin
            rsp.target           = cbm_pkg::TGT_BOOT;
            rsp.physical_address = {6'd0, req.address};
        end
        else if (req.address[15:14] == 2'b00)
        begin
            rsp.target           = cbm_pkg::TGT_ROM;
            rsp.physical_address = {6'd0, req.address};
        end
        else if (req.address[15:14] == 2'b01)
        begin
            rsp.target           = cbm_pkg::TGT_ROM;
            rsp.physical_address = {eff_bank, req.address[13:0]};
        end
        else if (in_ram_window)
        begin
            if (state_next.ram_enable_flag)
            begin
                rsp.target           = cbm_pkg::TGT_RAM;
                rsp.physical_address = {5'd0, ram_bank, req.address[12:0]};
            end
            else
            begin
                rsp.target = cbm_pkg::TGT_RAM_OFF;
            end
        end
    end

endmodule

// ===== hdl/cartridge_bank_mapper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_mapper: MBC1 / MBC3 style cartridge bank controller
// Maps CPU bus accesses to boot ROM, cartridge ROM or cartridge RAM and
// keeps the bank registers that control writes set.
//
//   channel  | signals                          | item
//   ---------+----------------------------------+-----------------------------
//   req      | req_valid, req_ready, req        | one bus access
//   rsp      | rsp_valid, rsp_ready, rsp        | target and physical address
//   cfg      | cfg_we, cfg_index, cfg_data      | configuration register write
//
// One item per cycle sustained while rsp is not stalled; an accepted req item
// passes the input register, then the result register, before rsp_valid
// rises for its rsp item.
// The bank state is read and updated in the single stage behind the input
// register, so consecutive items need no forwarding.
// A stalled rsp holds the result register; the input register still takes
// one more item, then req_ready drops.
// Reset restores the bank state and configuration registers to defaults.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  cbm_pkg::cbm_req_t                   req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output cbm_pkg::cbm_rsp_t                   rsp,
    input  logic                                cfg_we,
    input  logic [cbm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic                s1_valid_reg;
    cbm_pkg::cbm_req_t   s1_item_reg;
    logic                rsp_valid_reg;
    cbm_pkg::cbm_rsp_t   rsp_reg;
    cbm_pkg::cbm_state_t state_reg;
    cbm_pkg::cbm_state_t state_next;
    cbm_pkg::cbm_cfg_t   cfg_reg;
    cbm_pkg::cbm_rsp_t   rsp_next;
    logic                out_free;
    logic                s1_move;

    // Pipeline flow control
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign s1_move   = s1_valid_reg && out_free;
    assign req_ready = !s1_valid_reg || out_free;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Mapping logic
    cbm_core u_core (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .req        (s1_item_reg),
        .state_next (state_next),
        .rsp        (rsp_next)
    );

    // Valid bits and bank state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg                <= 1'b0;
            rsp_valid_reg               <= 1'b0;
            state_reg.rom_bank_select   <= 8'd1;
            state_reg.ram_bank_select   <= 4'd0;
            state_reg.ram_enable_flag   <= 1'b0;
            state_reg.ram_mode_flag     <= 1'b0;
            state_reg.boot_overlay_off  <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (out_free)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
            if (s1_move)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            s1_item_reg <= req;
        end
        if (s1_move)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mapper_kind      <= cbm_pkg::KIND_PLAIN;
            cfg_reg.rom_bank_count   <= 9'd2;
            cfg_reg.ram_bank_count   <= 5'd0;
            cfg_reg.boot_rom_present <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cbm_pkg::CFG_MAPPER_KIND:      cfg_reg.mapper_kind      <= cfg_data[1:0];
                cbm_pkg::CFG_ROM_BANK_COUNT:   cfg_reg.rom_bank_count   <= cfg_data[8:0];
                cbm_pkg::CFG_RAM_BANK_COUNT:   cfg_reg.ram_bank_count   <= cfg_data[4:0];
                cbm_pkg::CFG_BOOT_ROM_PRESENT: cfg_reg.boot_rom_present <= cfg_data[0];
                default:                       cfg_reg                  <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== hdl/cbm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_checker: port-level checks of the cartridge bank mapper
// Watches the top-level ports; attached to every instance by bind.
// ----------------------------------------------------------------------------
module cbm_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                req_valid,
    input logic                                req_ready,
    input cbm_pkg::cbm_req_t                   req,
    input logic                                rsp_valid,
    input logic                                rsp_ready,
    input cbm_pkg::cbm_rsp_t                   rsp,
    input logic                                cfg_we,
    input logic [cbm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input logic [cbm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // A stalled result item holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp item changed while stalled");

    // An empty output fills only from an accepted req item via the input register
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("rsp item with no accepted req item");

    // Boot ROM addresses stay inside the 256-byte overlay
    a_boot_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.target == cbm_pkg::TGT_BOOT |-> rsp.physical_address[21:8] == 14'd0)
        else $error("boot ROM address out of range");

    // No address and no RAM write off the cartridge or with RAM disabled
    a_no_target: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.target == cbm_pkg::TGT_NONE || rsp.target == cbm_pkg::TGT_RAM_OFF)
        |-> rsp.physical_address == 22'd0 && !rsp.ram_write)
        else $error("address or RAM write without a target");

    // RAM writes only land in enabled cartridge RAM
    a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.ram_write |-> rsp.target == cbm_pkg::TGT_RAM && rsp.ram_on)
        else $error("RAM write outside enabled RAM");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (.*);
